// File: rtl/core/udw_pkg.sv
// Shared constants, types and the codepoint width function for the UTF-8 width/clip block.
package udw_pkg;

    // Default byte counter width
    localparam int unsigned LEN_BITS_DEFAULT = 16;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TOTAL_W = 17;
    localparam int unsigned CLIP_W  = 16;
    localparam int unsigned CP_W    = 21;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 17'h1FFFF;
    localparam logic [CLIP_W-1:0]  CLIP_MAX   = 16'hFFFF;
    localparam logic [CLIP_W-1:0]  MAX_WIDTH_RESET = 16'hFFFF;

    // Byte class masks and patterns
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    // Display width of one codepoint, 0, 1 or 2 columns
    typedef logic [1:0] col_width_t;

    localparam col_width_t WIDTH_ZERO   = 2'd0;
    localparam col_width_t WIDTH_NARROW = 2'd1;
    localparam col_width_t WIDTH_WIDE   = 2'd2;

    function automatic logic cp_in(input logic [CP_W-1:0] cp,
                                   input logic [CP_W-1:0] lo,
                                   input logic [CP_W-1:0] hi);
        return (cp >= lo) && (cp <= hi);
    endfunction

    function automatic col_width_t cp_width(input logic [CP_W-1:0] cp);
        logic zero_w;
        logic wide_w;
        // controls, then combining marks
        zero_w = (cp < 21'h20) || cp_in(cp, 21'h7F, 21'h9F)
              || cp_in(cp, 21'h0300, 21'h036F) || cp_in(cp, 21'h1AB0, 21'h1AFF)
              || cp_in(cp, 21'h1DC0, 21'h1DFF) || cp_in(cp, 21'h20D0, 21'h20FF)
              || cp_in(cp, 21'hFE20, 21'hFE2F);
        // East Asian wide and fullwidth blocks
        wide_w = cp_in(cp, 21'h1100, 21'h115F) || cp_in(cp, 21'h2E80, 21'hA4CF)
              || cp_in(cp, 21'hAC00, 21'hD7A3) || cp_in(cp, 21'hF900, 21'hFAFF)
              || cp_in(cp, 21'hFE10, 21'hFE19) || cp_in(cp, 21'hFE30, 21'hFE6F)
              || cp_in(cp, 21'hFF00, 21'hFF60) || cp_in(cp, 21'hFFE0, 21'hFFE6);
        if (zero_w)
            return WIDTH_ZERO;
        else if (wide_w)
            return WIDTH_WIDE;
        else
            return WIDTH_NARROW;
    endfunction

endpackage

// File: rtl/core/udw_byte_if.sv
// Input channel: one string byte per transfer.
interface udw_byte_if
    import udw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

// File: rtl/core/udw_result_if.sv
// Result channel: total width and clip length of one string per transfer.
interface udw_result_if
    import udw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_width;
    logic [CLIP_W-1:0]  clip_length;

    modport source (output valid, output total_width, output clip_length, input ready);
    modport sink   (input valid, input total_width, input clip_length, output ready);
endinterface

// File: rtl/core/utf8_display_width_clip.sv
// Top level: UTF-8 decoder with display width total and column clip length.
//
// Takes a UTF-8 string one byte per transfer and returns, on the transfer of the
// byte marked is_last, one result with the string's total display width
// (saturating at 131071) and the length in bytes of the longest prefix whose
// width fits max_width. The block takes one byte every cycle; a string's result
// leaves through the result register. Stage one decodes the byte against
// the open sequence and looks up the codepoint width; stage two adds the width
// into the totals and the clip rule; the result register holds the answer while
// the next string streams in. Only a stalled result register holds the input.
// max_width must be written while no string is in flight.
module utf8_display_width_clip
    import udw_pkg::*;
#(
    parameter int unsigned LEN_BITS = LEN_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CLIP_W-1:0]   cfg_wdata,
    udw_byte_if.sink            text,
    udw_result_if.source        result
);

    localparam logic [LEN_BITS-1:0] POS_MAX = {LEN_BITS{1'b1}};

    logic                stall;
    logic                take;

    // configuration
    logic [CLIP_W-1:0]   max_width_reg;

    // decode state
    logic [1:0]          pending_reg, pending_next;
    logic [CP_W-1:0]     partial_reg, partial_next;
    logic [LEN_BITS-1:0] pos_reg, pos_next, pos_inc;
    logic                dec_done;
    logic [CP_W-1:0]     dec_cp;

    // stage one register
    logic                s1_valid_reg;
    logic                s1_done_reg;
    col_width_t          s1_width_reg;
    logic                s1_last_reg;
    logic [LEN_BITS-1:0] s1_pos_reg;

    // accumulate state
    logic [TOTAL_W-1:0]  wsum_reg, wsum_next;
    logic [CLIP_W-1:0]   csum_reg, csum_next;
    logic [LEN_BITS-1:0] cend_reg, cend_next;
    logic                cstop_reg, cstop_next;
    logic [TOTAL_W:0]    wsum_add;
    logic [CLIP_W:0]     csum_add;
    logic [CLIP_W-1:0]   cend_sat;

    // result register
    logic                out_valid_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic [CLIP_W-1:0]   out_clip_reg;

    // stall everything while a result waits
    assign stall      = out_valid_reg && !result.ready;
    assign text.ready = !stall;
    assign take       = text.valid && !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_width_reg <= MAX_WIDTH_RESET;
        else if (cfg_we)
            max_width_reg <= cfg_wdata;
    end

    // decode one byte against the open sequence
    always_comb
    begin
        pos_inc      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        dec_done     = 1'b0;
        dec_cp       = '0;
        pending_next = 2'd0;
        partial_next = '0;
        if ((pending_reg != 2'd0) && ((text.text_byte & CONT_MASK) == CONT_PAT))
        begin
            partial_next = {partial_reg[CP_W-7:0], text.text_byte[5:0]};
            pending_next = pending_reg - 2'd1;
            dec_done     = (pending_reg == 2'd1);
            dec_cp       = partial_next;
        end
        else if (!text.text_byte[7])
        begin
            dec_done = 1'b1;
            dec_cp   = {{(CP_W-BYTE_W){1'b0}}, text.text_byte};
        end
        else if ((text.text_byte & LEAD2_MASK) == LEAD2_PAT)
        begin
            partial_next = {{(CP_W-5){1'b0}}, text.text_byte[4:0]};
            pending_next = 2'd1;
        end
        else if ((text.text_byte & LEAD3_MASK) == LEAD3_PAT)
        begin
            partial_next = {{(CP_W-4){1'b0}}, text.text_byte[3:0]};
            pending_next = 2'd2;
        end
        else if ((text.text_byte & LEAD4_MASK) == LEAD4_PAT)
        begin
            partial_next = {{(CP_W-3){1'b0}}, text.text_byte[2:0]};
            pending_next = 2'd3;
        end
        pos_next = pos_inc;
        // drop any cut-off sequence at the end of the string
        if (text.is_last)
        begin
            pending_next = 2'd0;
            partial_next = '0;
            pos_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 2'd0;
            partial_reg  <= '0;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= text.valid;
            if (text.valid)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                pos_reg     <= pos_next;
            end
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_done_reg  <= dec_done;
            s1_width_reg <= cp_width(dec_cp);
            s1_last_reg  <= text.is_last;
            s1_pos_reg   <= pos_inc;
        end
    end

    // add width into the total and apply the clip rule
    always_comb
    begin
        wsum_next  = wsum_reg;
        csum_next  = csum_reg;
        cend_next  = cend_reg;
        cstop_next = cstop_reg;
        wsum_add   = {1'b0, wsum_reg} + {{(TOTAL_W-1){1'b0}}, s1_width_reg};
        csum_add   = {1'b0, csum_reg} + {{(CLIP_W-1){1'b0}}, s1_width_reg};
        if (s1_done_reg)
        begin
            wsum_next = wsum_add[TOTAL_W] ? TOTAL_MAX : wsum_add[TOTAL_W-1:0];
            if (!cstop_reg)
            begin
                if (csum_add > {1'b0, max_width_reg})
                    cstop_next = 1'b1;
                else
                begin
                    csum_next = csum_add[CLIP_W-1:0];
                    cend_next = s1_pos_reg;
                end
            end
        end
    end

    // saturate the clip end to the output width
    generate
        if (LEN_BITS > CLIP_W)
        begin : g_sat_wide
            assign cend_sat = (|cend_next[LEN_BITS-1:CLIP_W]) ? CLIP_MAX
                                                              : cend_next[CLIP_W-1:0];
        end
        else if (LEN_BITS == CLIP_W)
        begin : g_sat_same
            assign cend_sat = cend_next;
        end
        else
        begin : g_sat_narrow
            assign cend_sat = {{(CLIP_W-LEN_BITS){1'b0}}, cend_next};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsum_reg  <= '0;
            csum_reg  <= '0;
            cend_reg  <= '0;
            cstop_reg <= 1'b0;
        end
        else if (!stall && s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                wsum_reg  <= '0;
                csum_reg  <= '0;
                cend_reg  <= '0;
                cstop_reg <= 1'b0;
            end
            else
            begin
                wsum_reg  <= wsum_next;
                csum_reg  <= csum_next;
                cend_reg  <= cend_next;
                cstop_reg <= cstop_next;
            end
        end
    end

    // result register: load on the last byte, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!stall)
            out_valid_reg <= s1_valid_reg && s1_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!stall && s1_valid_reg && s1_last_reg)
        begin
            out_total_reg <= wsum_next;
            out_clip_reg  <= (max_width_reg == '0) ? '0 : cend_sat;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.total_width = out_total_reg;
    assign result.clip_length = out_clip_reg;

endmodule
